[hdl/twc_pkg.sv]
`timescale 1ns / 1ps

package twc_pkg;

    localparam int CHAR_W    = 8;
    localparam int COL_W     = 7;
    localparam int ROW_W     = 5;
    localparam int OP_W      = 2;
    localparam int OFS_W     = 12;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [COL_W-1:0] WIN_WIDTH_RESET  = 7'd80;
    localparam logic [ROW_W-1:0] WIN_HEIGHT_RESET = 5'd25;

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_LINEFEED  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

    typedef enum logic [OP_W-1:0] {
        OP_PRINT = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_MOVE  = 2'd3
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_COL = 2'd0,
        CFG_ORIGIN_ROW = 2'd1,
        CFG_WIN_WIDTH  = 2'd2,
        CFG_WIN_HEIGHT = 2'd3
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL_RD,
        ST_SCROLL_WR,
        ST_FILL
    } t_state;

    typedef enum logic [2:0] {
        DP_NONE,
        DP_INIT,
        DP_ACCEPT,
        DP_READ_DONE,
        DP_SCROLL_RD,
        DP_SCROLL_WR,
        DP_FILL
    } t_dp_op;

    typedef enum logic [1:0] {
        JOB_DONE,
        JOB_READ,
        JOB_SCROLL,
        JOB_CLEAR
    } t_job;

    typedef struct packed {
        logic init_last;
        logic col_last;
        logic row_last;
        logic row_next_last;
        logic single_row;
        t_job job;
    } t_dp_status;

endpackage

[hdl/twc_ctrl.sv]
`timescale 1ns / 1ps

module twc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_stall,
    input  twc_pkg::t_dp_status i_status,
    output twc_pkg::t_dp_op     o_cmd,
    output logic                o_in_stall,
    output logic                o_out_valid
);
    import twc_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   can_take;
    logic   accept;
    logic   done;
    logic   walk_end;

    assign can_take = (r_state == ST_IDLE) && (!r_out_valid || !i_out_stall);
    assign accept   = i_in_valid && can_take;
    assign walk_end = i_status.col_last && i_status.row_last;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (i_status.init_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (i_status.job)
                        JOB_DONE:   n_state = ST_IDLE;
                        JOB_READ:   n_state = ST_READ;
                        JOB_SCROLL: n_state = i_status.single_row ? ST_FILL : ST_SCROLL_RD;
                        JOB_CLEAR:  n_state = ST_FILL;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_READ:      n_state = ST_IDLE;
            ST_SCROLL_RD: n_state = ST_SCROLL_WR;
            ST_SCROLL_WR: begin
                if (i_status.col_last && i_status.row_next_last) begin
                    n_state = ST_FILL;
                end else begin
                    n_state = ST_SCROLL_RD;
                end
            end
            ST_FILL: begin
                if (walk_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_INIT;
        endcase
    end

    always_comb begin
        o_cmd = DP_NONE;
        done  = 1'b0;
        case (r_state)
            ST_INIT: o_cmd = DP_INIT;
            ST_IDLE: begin
                if (accept) begin
                    o_cmd = DP_ACCEPT;
                    done  = (i_status.job == JOB_DONE);
                end
            end
            ST_READ: begin
                o_cmd = DP_READ_DONE;
                done  = 1'b1;
            end
            ST_SCROLL_RD: o_cmd = DP_SCROLL_RD;
            ST_SCROLL_WR: o_cmd = DP_SCROLL_WR;
            ST_FILL: begin
                o_cmd = DP_FILL;
                done  = walk_end;
            end
            default: o_cmd = DP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = !can_take;
    assign o_out_valid = r_out_valid;

endmodule

[hdl/twc_datapath.sv]
`timescale 1ns / 1ps

module twc_datapath #(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 25
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [twc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [twc_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic [twc_pkg::OP_W-1:0]       i_opcode,
    input  logic [twc_pkg::CHAR_W-1:0]     i_char_in,
    input  logic [twc_pkg::COL_W-1:0]      i_col,
    input  logic [twc_pkg::ROW_W-1:0]      i_row,
    input  twc_pkg::t_dp_op                i_cmd,
    output twc_pkg::t_dp_status            o_status,
    output logic [twc_pkg::CHAR_W-1:0]     o_char_out,
    output logic                           o_wrote,
    output logic [twc_pkg::OFS_W-1:0]      o_screen_offset,
    output logic [twc_pkg::COL_W-1:0]      o_cursor_col_out,
    output logic [twc_pkg::ROW_W-1:0]      o_cursor_row_out,
    output logic                           o_scrolled,
    output logic                           o_range_error
);
    import twc_pkg::*;

    localparam int CELLS  = SCREEN_COLS * SCREEN_ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int SC_W   = COL_W + 1;
    localparam int SR_W   = ROW_W + 1;

    logic [COL_W-1:0]  r_origin_col;
    logic [ROW_W-1:0]  r_origin_row;
    logic [COL_W-1:0]  r_win_width;
    logic [ROW_W-1:0]  r_win_height;
    logic [COL_W-1:0]  r_cur_col;
    logic [ROW_W-1:0]  r_cur_row;
    logic [COL_W-1:0]  r_wx;
    logic [ROW_W-1:0]  r_wy;
    logic [ADDR_W-1:0] r_init_cnt;
    logic              r_src_on;
    logic              r_rd_on;
    logic [CHAR_W-1:0] r_rdata;
    logic [CHAR_W-1:0] r_mem [CELLS];

    logic [CHAR_W-1:0] r_char;
    logic              r_wrote;
    logic [OFS_W-1:0]  r_offs;
    logic [COL_W-1:0]  r_ccol;
    logic [ROW_W-1:0]  r_crow;
    logic              r_scrolled;
    logic              r_rerr;

    logic [COL_W-1:0]  win_w;
    logic [ROW_W-1:0]  win_h;
    logic [COL_W-1:0]  a_col;
    logic [ROW_W-1:0]  a_row;
    logic [SC_W-1:0]   sc;
    logic [SR_W-1:0]   sr;
    logic              on_screen;
    logic [ADDR_W-1:0] cell_idx;
    logic [OFS_W-1:0]  cell_ofs;
    t_opcode           op;

    logic              is_nl;
    logic              is_bs;
    logic              col_wrap;
    logic              row_last_cur;
    logic              in_win;
    logic              do_lf;
    logic              prt_write;
    logic [COL_W-1:0]  n_cur_col;
    logic [ROW_W-1:0]  n_cur_row;
    logic [CHAR_W-1:0] n_char;
    logic              n_wrote;
    logic [OFS_W-1:0]  n_offs;
    logic              n_scrolled;
    logic              n_rerr;
    t_job              n_job;

    logic [ADDR_W-1:0] store_addr;
    logic              mem_we;
    logic [CHAR_W-1:0] mem_wdata;

    assign win_w = (r_win_width == '0) ? COL_W'(1) : r_win_width;
    assign win_h = (r_win_height == '0) ? ROW_W'(1) : r_win_height;
    assign op    = t_opcode'(i_opcode);

    always_comb begin
        case (i_cmd)
            DP_ACCEPT: begin
                if (op == OP_PRINT) begin
                    a_col = r_cur_col;
                    a_row = r_cur_row;
                end else begin
                    a_col = i_col;
                    a_row = i_row;
                end
            end
            DP_SCROLL_RD: begin
                a_col = r_wx;
                a_row = r_wy + ROW_W'(1);
            end
            default: begin
                a_col = r_wx;
                a_row = r_wy;
            end
        endcase
    end

    assign sc        = SC_W'(a_col) + SC_W'(r_origin_col);
    assign sr        = SR_W'(a_row) + SR_W'(r_origin_row);
    assign on_screen = (32'(sc) < SCREEN_COLS) && (32'(sr) < SCREEN_ROWS);
    assign cell_idx  = ADDR_W'(32'(sr) * SCREEN_COLS + 32'(sc));
    assign cell_ofs  = OFS_W'(2 * 32'(sc) + 2 * SCREEN_COLS * 32'(sr));

    assign is_nl        = (i_char_in == CH_LINEFEED) || (i_char_in == CH_RETURN);
    assign is_bs        = (i_char_in == CH_BACKSPACE);
    assign col_wrap     = (SC_W'(r_cur_col) + SC_W'(1)) >= SC_W'(win_w);
    assign row_last_cur = (SR_W'(r_cur_row) + SR_W'(1)) >= SR_W'(win_h);
    assign in_win       = (i_col < win_w) && (i_row < win_h);

    always_comb begin
        n_cur_col  = r_cur_col;
        n_cur_row  = r_cur_row;
        n_char     = '0;
        n_wrote    = 1'b0;
        n_offs     = '0;
        n_scrolled = 1'b0;
        n_rerr     = 1'b0;
        n_job      = JOB_DONE;
        do_lf      = 1'b0;
        prt_write  = 1'b0;
        case (op)
            OP_PRINT: begin
                if (is_nl) begin
                    do_lf = 1'b1;
                end else if (is_bs) begin
                    if (r_cur_col != '0) begin
                        n_cur_col = r_cur_col - COL_W'(1);
                    end
                end else begin
                    n_char    = i_char_in;
                    n_wrote   = on_screen;
                    n_offs    = cell_ofs;
                    prt_write = 1'b1;
                    if (col_wrap) begin
                        do_lf = 1'b1;
                    end else begin
                        n_cur_col = r_cur_col + COL_W'(1);
                    end
                end
            end
            OP_READ: begin
                n_offs = cell_ofs;
                n_rerr = !in_win;
                n_job  = JOB_READ;
            end
            OP_CLEAR: begin
                n_cur_col = '0;
                n_cur_row = '0;
                n_job     = JOB_CLEAR;
            end
            OP_MOVE: begin
                n_offs = cell_ofs;
                if (in_win) begin
                    n_cur_col = i_col;
                    n_cur_row = i_row;
                end else begin
                    n_rerr = 1'b1;
                end
            end
            default: n_job = JOB_DONE;
        endcase
        if (do_lf) begin
            n_cur_col = '0;
            if (row_last_cur) begin
                n_cur_row  = win_h - ROW_W'(1);
                n_scrolled = 1'b1;
                n_job      = JOB_SCROLL;
            end else begin
                n_cur_row = r_cur_row + ROW_W'(1);
            end
        end
    end

    always_comb begin
        store_addr = cell_idx;
        mem_we     = 1'b0;
        mem_wdata  = CH_BLANK;
        case (i_cmd)
            DP_INIT: begin
                store_addr = r_init_cnt;
                mem_we     = 1'b1;
            end
            DP_ACCEPT: begin
                mem_we    = prt_write && on_screen;
                mem_wdata = i_char_in;
            end
            DP_SCROLL_WR: begin
                mem_we    = on_screen;
                mem_wdata = r_src_on ? r_rdata : CH_BLANK;
            end
            DP_FILL: mem_we = on_screen;
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[store_addr] <= mem_wdata;
        end
        r_rdata <= r_mem[store_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_col <= '0;
            r_origin_row <= '0;
            r_win_width  <= WIN_WIDTH_RESET;
            r_win_height <= WIN_HEIGHT_RESET;
            r_cur_col    <= '0;
            r_cur_row    <= '0;
            r_wx         <= '0;
            r_wy         <= '0;
            r_init_cnt   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_ORIGIN_COL: r_origin_col <= i_cfg_data;
                    CFG_ORIGIN_ROW: r_origin_row <= i_cfg_data[ROW_W-1:0];
                    CFG_WIN_WIDTH:  r_win_width  <= i_cfg_data;
                    CFG_WIN_HEIGHT: r_win_height <= i_cfg_data[ROW_W-1:0];
                    default: ;
                endcase
            end
            case (i_cmd)
                DP_INIT: r_init_cnt <= r_init_cnt + ADDR_W'(1);
                DP_ACCEPT: begin
                    r_cur_col <= n_cur_col;
                    r_cur_row <= n_cur_row;
                    r_wx      <= '0;
                    r_wy      <= '0;
                end
                DP_SCROLL_WR, DP_FILL: begin
                    if (o_status.col_last) begin
                        r_wx <= '0;
                        r_wy <= r_wy + ROW_W'(1);
                    end else begin
                        r_wx <= r_wx + COL_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            DP_ACCEPT: begin
                r_char     <= n_char;
                r_wrote    <= n_wrote;
                r_offs     <= n_offs;
                r_ccol     <= n_cur_col;
                r_crow     <= n_cur_row;
                r_scrolled <= n_scrolled;
                r_rerr     <= n_rerr;
                r_rd_on    <= on_screen;
            end
            DP_READ_DONE: begin
                if (r_rerr) begin
                    r_char <= '0;
                end else if (r_rd_on) begin
                    r_char <= r_rdata;
                end else begin
                    r_char <= CH_BLANK;
                end
            end
            DP_SCROLL_RD: r_src_on <= on_screen;
            default: ;
        endcase
    end

    assign o_status.init_last     = (r_init_cnt == ADDR_W'(CELLS - 1));
    assign o_status.col_last      = (r_wx == win_w - COL_W'(1));
    assign o_status.row_last      = (r_wy == win_h - ROW_W'(1));
    assign o_status.row_next_last = ((SR_W'(r_wy) + SR_W'(2)) == SR_W'(win_h));
    assign o_status.single_row    = (win_h == ROW_W'(1));
    assign o_status.job           = n_job;

    assign o_char_out       = r_char;
    assign o_wrote          = r_wrote;
    assign o_screen_offset  = r_offs;
    assign o_cursor_col_out = r_ccol;
    assign o_cursor_row_out = r_crow;
    assign o_scrolled       = r_scrolled;
    assign o_range_error    = r_rerr;

endmodule

[hdl/text_window_console.sv]
// Print without scroll, move, newline, backspace: word valid the cycle after accept,
// 1 item/cycle while output is not stalled. Read: the cell store read port is registered.
// Print that scrolls: read then write for each of the W*(H-1) moved cells, then W blank cells.
// Clear: one cell write per cycle over all W*H cells. W, H: effective window width, height.
// Reset: synchronous, active low; then a clearing pass writes spaces to the store's
// SCREEN_COLS*SCREEN_ROWS cells while input is stalled (configuration writes still taken).
`timescale 1ns / 1ps

module text_window_console #(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 25
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [twc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [twc_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [twc_pkg::OP_W-1:0]      i_opcode,
    input  logic [twc_pkg::CHAR_W-1:0]    i_char_in,
    input  logic [twc_pkg::COL_W-1:0]     i_col,
    input  logic [twc_pkg::ROW_W-1:0]     i_row,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [twc_pkg::CHAR_W-1:0]    o_char_out,
    output logic                          o_wrote,
    output logic [twc_pkg::OFS_W-1:0]     o_screen_offset,
    output logic [twc_pkg::COL_W-1:0]     o_cursor_col_out,
    output logic [twc_pkg::ROW_W-1:0]     o_cursor_row_out,
    output logic                          o_scrolled,
    output logic                          o_range_error
);
    import twc_pkg::*;

    t_dp_op     cmd;
    t_dp_status status;

    twc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    twc_datapath #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_opcode         (i_opcode),
        .i_char_in        (i_char_in),
        .i_col            (i_col),
        .i_row            (i_row),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_char_out       (o_char_out),
        .o_wrote          (o_wrote),
        .o_screen_offset  (o_screen_offset),
        .o_cursor_col_out (o_cursor_col_out),
        .o_cursor_row_out (o_cursor_row_out),
        .o_scrolled       (o_scrolled),
        .o_range_error    (o_range_error)
    );

endmodule

[hdl/twc_checker.sv]
`timescale 1ns / 1ps

module twc_assertions (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_stall,
    input logic                          i_out_valid,
    input logic                          i_out_stall,
    input logic [twc_pkg::CHAR_W-1:0]    i_char_out,
    input logic                          i_wrote,
    input logic [twc_pkg::OFS_W-1:0]     i_screen_offset,
    input logic [twc_pkg::COL_W-1:0]     i_cursor_col_out,
    input logic                          i_scrolled,
    input logic                          i_range_error
);
    import twc_pkg::*;

    a_init_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> i_in_stall)
        else $error("input not stalled right after reset");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid)
        else $error("output word dropped while stalled");

    a_word_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> $stable(i_char_out) && $stable(i_screen_offset)
            && $stable(i_cursor_col_out))
        else $error("output word changed while stalled");

    a_scroll_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_scrolled |-> (i_cursor_col_out == '0) && !i_range_error)
        else $error("scroll left cursor off column zero");

    a_wrote_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_wrote |-> !i_range_error)
        else $error("store write flagged with range error");

endmodule

bind text_window_console twc_assertions u_twc_assertions (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_stall       (o_in_stall),
    .i_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .i_char_out       (o_char_out),
    .i_wrote          (o_wrote),
    .i_screen_offset  (o_screen_offset),
    .i_cursor_col_out (o_cursor_col_out),
    .i_scrolled       (o_scrolled),
    .i_range_error    (o_range_error)
);

[tb/twc_checker.sv]
`timescale 1ns / 1ps

module twc_checker #(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 25
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [twc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [twc_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [twc_pkg::OP_W-1:0]      i_opcode,
    input  logic [twc_pkg::CHAR_W-1:0]    i_char_in,
    input  logic [twc_pkg::COL_W-1:0]     i_col,
    input  logic [twc_pkg::ROW_W-1:0]     i_row,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [twc_pkg::CHAR_W-1:0]    i_char_out,
    input  logic                          i_wrote,
    input  logic [twc_pkg::OFS_W-1:0]     i_screen_offset,
    input  logic [twc_pkg::COL_W-1:0]     i_cursor_col,
    input  logic [twc_pkg::ROW_W-1:0]     i_cursor_row,
    input  logic                          i_scrolled,
    input  logic                          i_range_error,
    output int                            o_failures,
    output int                            o_pending
);

    import twc_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              wrote;
        logic [OFS_W-1:0]  offset;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic              scrolled;
        logic              range_error;
    } console_word_t;

    logic [CHAR_W-1:0] screen [SCREEN_COLS*SCREEN_ROWS];
    int cur_col;
    int cur_row;
    int org_col;
    int org_row;
    int win_cols_reg;
    int win_rows_reg;
    console_word_t expected_words[$];
    console_word_t want;
    console_word_t got;

    function automatic int win_cols();
        return (win_cols_reg == 0) ? 1 : win_cols_reg;
    endfunction

    function automatic int win_rows();
        return (win_rows_reg == 0) ? 1 : win_rows_reg;
    endfunction

    function automatic logic [OFS_W-1:0] video_offset(int c, int r);
        int v;
        v = 2 * (c + org_col) + 2 * SCREEN_COLS * (r + org_row);
        return v[OFS_W-1:0];
    endfunction

    function automatic bit cell_slot(int c, int r, output int idx);
        int sc;
        int sr;
        sc = c + org_col;
        sr = r + org_row;
        idx = sr * SCREEN_COLS + sc;
        return (sc < SCREEN_COLS) && (sr < SCREEN_ROWS);
    endfunction

    function automatic logic [CHAR_W-1:0] peek_cell(int c, int r);
        int idx;
        if (cell_slot(c, r, idx)) begin
            return screen[idx];
        end
        return CH_BLANK;
    endfunction

    function automatic bit poke_cell(int c, int r, logic [CHAR_W-1:0] v);
        int idx;
        if (!cell_slot(c, r, idx)) begin
            return 1'b0;
        end
        screen[idx] = v;
        return 1'b1;
    endfunction

    function automatic void scroll_window();
        int w;
        int h;
        w = win_cols();
        h = win_rows();
        for (int y = 0; y + 1 < h; y++) begin
            for (int x = 0; x < w; x++) begin
                void'(poke_cell(x, y, peek_cell(x, y + 1)));
            end
        end
        for (int x = 0; x < w; x++) begin
            void'(poke_cell(x, h - 1, CH_BLANK));
        end
        cur_col = 0;
        cur_row = h - 1;
    endfunction

    function automatic bit line_feed();
        if (cur_row + 1 >= win_rows()) begin
            scroll_window();
            return 1'b1;
        end
        cur_col = 0;
        cur_row = cur_row + 1;
        return 1'b0;
    endfunction

    function automatic console_word_t console_step(t_opcode op, logic [CHAR_W-1:0] ch,
                                                   int c, int r);
        console_word_t res;
        int w;
        int h;
        res = '0;
        w = win_cols();
        h = win_rows();
        case (op)
            OP_PRINT: begin
                if (ch == CH_LINEFEED || ch == CH_RETURN) begin
                    res.scrolled = line_feed();
                end else if (ch == CH_BACKSPACE) begin
                    if (cur_col != 0) begin
                        cur_col = cur_col - 1;
                    end
                end else begin
                    res.offset   = video_offset(cur_col, cur_row);
                    res.char_out = ch;
                    res.wrote    = poke_cell(cur_col, cur_row, ch);
                    if (cur_col + 1 >= w) begin
                        res.scrolled = line_feed();
                    end else begin
                        cur_col = cur_col + 1;
                    end
                end
            end
            OP_READ: begin
                res.offset = video_offset(c, r);
                if (c < w && r < h) begin
                    res.char_out = peek_cell(c, r);
                end else begin
                    res.range_error = 1'b1;
                end
            end
            OP_CLEAR: begin
                for (int y = 0; y < h; y++) begin
                    for (int x = 0; x < w; x++) begin
                        void'(poke_cell(x, y, CH_BLANK));
                    end
                end
                cur_col = 0;
                cur_row = 0;
            end
            OP_MOVE: begin
                res.offset = video_offset(c, r);
                if (c < w && r < h) begin
                    cur_col = c;
                    cur_row = r;
                end else begin
                    res.range_error = 1'b1;
                end
            end
        endcase
        res.cursor_col = cur_col[COL_W-1:0];
        res.cursor_row = cur_row[ROW_W-1:0];
        return res;
    endfunction

    function automatic void reset_console();
        for (int i = 0; i < SCREEN_COLS * SCREEN_ROWS; i++) begin
            screen[i] = CH_BLANK;
        end
        cur_col      = 0;
        cur_row      = 0;
        org_col      = 0;
        org_row      = 0;
        win_cols_reg = WIN_WIDTH_RESET;
        win_rows_reg = WIN_HEIGHT_RESET;
        expected_words.delete();
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_console();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = {i_char_out, i_wrote, i_screen_offset, i_cursor_col, i_cursor_row,
                       i_scrolled, i_range_error};
                if (expected_words.size() == 0) begin
                    $error("result word with no prediction pending");
                    o_failures++;
                end else begin
                    want = expected_words.pop_front();
                    if (got.char_out !== want.char_out) begin
                        $error("char_out: expected %0d, got %0d", want.char_out, got.char_out);
                        o_failures++;
                    end
                    if (got.wrote !== want.wrote) begin
                        $error("wrote: expected %0d, got %0d", want.wrote, got.wrote);
                        o_failures++;
                    end
                    if (got.offset !== want.offset) begin
                        $error("screen_offset: expected %0d, got %0d", want.offset, got.offset);
                        o_failures++;
                    end
                    if (got.cursor_col !== want.cursor_col) begin
                        $error("cursor_col_out: expected %0d, got %0d",
                               want.cursor_col, got.cursor_col);
                        o_failures++;
                    end
                    if (got.cursor_row !== want.cursor_row) begin
                        $error("cursor_row_out: expected %0d, got %0d",
                               want.cursor_row, got.cursor_row);
                        o_failures++;
                    end
                    if (got.scrolled !== want.scrolled) begin
                        $error("scrolled: expected %0d, got %0d", want.scrolled, got.scrolled);
                        o_failures++;
                    end
                    if (got.range_error !== want.range_error) begin
                        $error("range_error: expected %0d, got %0d",
                               want.range_error, got.range_error);
                        o_failures++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_ORIGIN_COL: org_col      = i_cfg_data[COL_W-1:0];
                    CFG_ORIGIN_ROW: org_row      = i_cfg_data[ROW_W-1:0];
                    CFG_WIN_WIDTH:  win_cols_reg = i_cfg_data[COL_W-1:0];
                    CFG_WIN_HEIGHT: win_rows_reg = i_cfg_data[ROW_W-1:0];
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                expected_words.push_back(console_step(t_opcode'(i_opcode), i_char_in,
                                                      i_col, i_row));
            end
        end
        o_pending = expected_words.size();
    end

endmodule

[tb/text_window_console_tb.sv]
`timescale 1ns / 1ps

module text_window_console_tb;

    import twc_pkg::*;

    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int RANDOM_WORDS = 1400;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [OP_W-1:0]      i_opcode;
    logic [CHAR_W-1:0]    i_char_in;
    logic [COL_W-1:0]     i_col;
    logic [ROW_W-1:0]     i_row;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [CHAR_W-1:0]    o_char_out;
    logic                 o_wrote;
    logic [OFS_W-1:0]     o_screen_offset;
    logic [COL_W-1:0]     o_cursor_col_out;
    logic [ROW_W-1:0]     o_cursor_row_out;
    logic                 o_scrolled;
    logic                 o_range_error;

    int failures;
    int pending;
    int cycle_count = 0;
    int sent_random = 0;
    int win_cols = 80;
    int win_rows = 25;
    bit in_calm = 1'b0;
    bit out_calm = 1'b0;

    text_window_console dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_char_in        (i_char_in),
        .i_col            (i_col),
        .i_row            (i_row),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_char_out       (o_char_out),
        .o_wrote          (o_wrote),
        .o_screen_offset  (o_screen_offset),
        .o_cursor_col_out (o_cursor_col_out),
        .o_cursor_row_out (o_cursor_row_out),
        .o_scrolled       (o_scrolled),
        .o_range_error    (o_range_error)
    );

    twc_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_char_in       (i_char_in),
        .i_col           (i_col),
        .i_row           (i_row),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_char_out      (o_char_out),
        .i_wrote         (o_wrote),
        .i_screen_offset (o_screen_offset),
        .i_cursor_col    (o_cursor_col_out),
        .i_cursor_row    (o_cursor_row_out),
        .i_scrolled      (o_scrolled),
        .i_range_error   (o_range_error),
        .o_failures      (failures),
        .o_pending       (pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int hold;
        i_out_stall = 1'b0;
        forever begin
            hold = out_calm ? 0 : $urandom_range(0, 9);
            @(negedge i_clk);
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic send_word(t_opcode op, logic [CHAR_W-1:0] ch, logic [COL_W-1:0] col,
                             logic [ROW_W-1:0] row);
        int gap;
        gap = in_calm ? 0 : $urandom_range(0, 9);
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_char_in  <= ch;
        i_col      <= col;
        i_row      <= row;
        // hold the word until taken
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic print_char(logic [CHAR_W-1:0] ch);
        send_word(OP_PRINT, ch, COL_W'($urandom_range(0, 79)), ROW_W'($urandom_range(0, 24)));
    endtask

    task automatic aim(t_opcode op, logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
        send_word(op, CHAR_W'($urandom_range(0, 255)), col, row);
    endtask

    task automatic drain();
        // drop valid so the last word is not taken twice
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_index idx, int value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_window(int oc, int orow, int w, int h);
        drain();
        cfg_write(CFG_ORIGIN_COL, oc);
        cfg_write(CFG_ORIGIN_ROW, orow);
        cfg_write(CFG_WIN_WIDTH, w);
        cfg_write(CFG_WIN_HEIGHT, h);
        win_cols = (w == 0) ? 1 : w;
        win_rows = (h == 0) ? 1 : h;
    endtask

    task automatic random_item(bit roomy);
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [CHAR_W-1:0] ch;
        int pick;
        int sub;
        if ($urandom_range(0, 4) == 0) begin
            col = COL_W'($urandom_range(0, 79));
            row = ROW_W'($urandom_range(0, 24));
        end else begin
            col = COL_W'($urandom_range(0, win_cols - 1));
            row = ROW_W'($urandom_range(0, win_rows - 1));
        end
        ch = CHAR_W'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            sub = $urandom_range(0, 99);
            if (sub < (roomy ? 2 : 10)) begin
                ch = CH_LINEFEED;
            end else if (sub < (roomy ? 4 : 14)) begin
                ch = CH_RETURN;
            end else if (sub < 22) begin
                ch = CH_BACKSPACE;
            end
            send_word(OP_PRINT, ch, col, row);
        end else if (pick < 72) begin
            send_word(OP_READ, ch, col, row);
        end else if (pick < (roomy ? 73 : 77)) begin
            send_word(OP_CLEAR, ch, col, row);
        end else begin
            send_word(OP_MOVE, ch, col, row);
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_ORIGIN_COL;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_opcode    = OP_PRINT;
        i_char_in   = '0;
        i_col       = '0;
        i_row       = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        aim(OP_READ, 7'd79, 5'd24);
        print_char(8'h41);
        print_char(8'hFF);
        print_char(8'h00);
        print_char(CH_BACKSPACE);
        print_char(CH_RETURN);
        aim(OP_MOVE, 7'd79, 5'd24);
        print_char(8'h5A);
        aim(OP_MOVE, 7'd0, 5'd0);
        print_char(CH_BACKSPACE);
        print_char(CH_LINEFEED);
        aim(OP_CLEAR, 7'd55, 5'd17);

        set_window(75, 22, 10, 5);
        print_char(8'h78);
        aim(OP_MOVE, 7'd9, 5'd4);
        print_char(8'h79);
        aim(OP_READ, 7'd9, 5'd4);
        aim(OP_READ, 7'd10, 5'd0);
        aim(OP_MOVE, 7'd0, 5'd5);
        aim(OP_READ, 7'd79, 5'd24);

        set_window(79, 24, 0, 0);
        print_char(8'h71);
        aim(OP_READ, 7'd0, 5'd0);
        aim(OP_READ, 7'd1, 5'd0);
        print_char(CH_LINEFEED);

        set_window(0, 0, 80, 25);
        aim(OP_MOVE, 7'd70, 5'd20);
        set_window(0, 0, 10, 5);
        print_char(8'h6B);
        print_char(CH_LINEFEED);

        while (sent_random < RANDOM_WORDS) begin
            int oc;
            int orow;
            int w;
            int h;
            int burst;
            bit roomy;
            case ($urandom_range(0, 3))
                0:       oc = 0;
                1:       oc = 79;
                default: oc = $urandom_range(0, 79);
            endcase
            case ($urandom_range(0, 3))
                0:       orow = 0;
                1:       orow = 24;
                default: orow = $urandom_range(0, 24);
            endcase
            roomy = ($urandom_range(0, 4) == 0);
            if (roomy) begin
                w = ($urandom_range(0, 1) == 0) ? 80 : $urandom_range(13, 80);
                h = ($urandom_range(0, 1) == 0) ? 25 : $urandom_range(7, 25);
            end else begin
                w = $urandom_range(0, 12);
                h = $urandom_range(0, 6);
            end
            set_window(oc, orow, w, h);
            in_calm  = ($urandom_range(0, 3) == 0);
            out_calm = ($urandom_range(0, 3) == 0);
            burst = roomy ? 25 : 70;
            repeat (burst) begin
                random_item(roomy);
                sent_random++;
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (failures == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[text_window_console.f]
hdl/twc_pkg.sv
hdl/twc_ctrl.sv
hdl/twc_datapath.sv
hdl/text_window_console.sv
hdl/twc_checker.sv
tb/twc_checker.sv
tb/text_window_console_tb.sv
